/* src/b64ld_pkg.sv */
// ----------------------------------------------------------------------------
// Base64 lenient decoder package
// Shared types, constants and the alphabet lookup for the decoder.
// ----------------------------------------------------------------------------
package b64ld_pkg;

    // Character constants.
    localparam logic [7:0] PAD_CHAR = 8'h3D;   // '='

    // Accumulator holds up to three sextets.
    localparam int ACC_W    = 18;
    localparam int FULL_W   = 24;

    // Output queue geometry.
    localparam int Q_DEPTH  = 8;
    localparam int Q_AW     = $clog2(Q_DEPTH);
    localparam int Q_CW     = $clog2(Q_DEPTH + 1);
    localparam int MAX_PUSH = 3;

    // One decoded result word.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
        logic       out_error;
    } t_result;

    // Group of results produced by one accepted input word.
    typedef struct packed {
        logic [1:0]        count;
        t_result [2:0]     item;
    } t_push;

    // Queue status seen by the top level.
    typedef struct packed {
        logic [Q_CW-1:0] level;
    } t_q_status;

    // Lookup result of one character.
    typedef struct packed {
        logic       ok;
        logic [5:0] sextet;
    } t_sym;

    // Map a character to its six-bit value under the selected alphabet.
    function automatic t_sym sextet_lookup(input logic [7:0] b, input logic url);
        t_sym r;
        r.ok     = 1'b1;
        r.sextet = 6'd0;
        if (b inside {[8'h41:8'h5A]}) begin
            r.sextet = 6'(b - 8'h41);
        end else if (b inside {[8'h61:8'h7A]}) begin
            r.sextet = 6'(b - 8'h61 + 8'd26);
        end else if (b inside {[8'h30:8'h39]}) begin
            r.sextet = 6'(b - 8'h30 + 8'd52);
        end else if (url && b == 8'h2D) begin
            r.sextet = 6'd62;
        end else if (url && b == 8'h5F) begin
            r.sextet = 6'd63;
        end else if (!url && b == 8'h2B) begin
            r.sextet = 6'd62;
        end else if (!url && b == 8'h2F) begin
            r.sextet = 6'd63;
        end else begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

endpackage

/* src/b64ld_if.sv */
// ----------------------------------------------------------------------------
// Base64 lenient decoder channels
// Valid/ready channels for encoded input, decoded output and configuration.
// ----------------------------------------------------------------------------

// Encoded character channel.
interface b64ld_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// Decoded byte channel.
interface b64ld_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;
    logic       out_error;

    modport source (output valid, output out_byte, output out_last, output out_error,
                    input ready);
    modport sink   (input valid, input out_byte, input out_last, input out_error,
                    output ready);
endinterface

// Configuration write channel.
interface b64ld_cfg_if;
    logic valid;
    logic ready;
    logic url_alphabet;

    modport source (output valid, output url_alphabet, input ready);
    modport sink   (input valid, input url_alphabet, output ready);
endinterface

/* src/b64ld_core.sv */
// ----------------------------------------------------------------------------
// Base64 lenient decoder core
// Holds the message state and turns one accepted word into up to three results.
// ----------------------------------------------------------------------------
module b64ld_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [7:0]         i_byte,
    input  logic               i_last,
    input  logic               i_cfg_we,
    input  logic               i_cfg_url,
    output b64ld_pkg::t_push   o_push
);

    logic [b64ld_pkg::ACC_W-1:0] r_acc, n_acc;
    logic [1:0]                  r_phase, n_phase;
    logic [1:0]                  r_pad, n_pad;
    logic                        r_err, n_err;
    logic                        r_url;

    b64ld_pkg::t_sym             sym;
    logic [b64ld_pkg::FULL_W-1:0] full;
    b64ld_pkg::t_push            push;

    assign sym  = b64ld_pkg::sextet_lookup(i_byte, r_url);
    assign full = {r_acc, sym.sextet};

    // Decode one word: symbol step, then the message-end check.
    always_comb begin
        n_acc   = r_acc;
        n_phase = r_phase;
        n_pad   = r_pad;
        n_err   = r_err;
        push    = '0;

        if (!r_err) begin
            if (i_byte == b64ld_pkg::PAD_CHAR) begin
                if (r_pad >= 2'd2) begin
                    n_err = 1'b1;
                end else begin
                    n_pad = r_pad + 2'd1;
                end
            end else if (!sym.ok || r_pad != 2'd0) begin
                n_err = 1'b1;
            end else if (r_phase == 2'd3) begin
                push.count   = 2'd3;
                push.item[0] = '{out_byte: full[23:16], out_last: 1'b0, out_error: 1'b0};
                push.item[1] = '{out_byte: full[15:8],  out_last: 1'b0, out_error: 1'b0};
                push.item[2] = '{out_byte: full[7:0],   out_last: i_last, out_error: 1'b0};
                n_acc        = '0;
                n_phase      = 2'd0;
            end else begin
                n_acc   = {r_acc[b64ld_pkg::ACC_W-7:0], sym.sextet};
                n_phase = r_phase + 2'd1;
            end
        end

        if (i_last) begin
            if (!n_err) begin
                case (n_phase)
                    2'd0: begin
                        if (n_pad != 2'd0) begin
                            n_err = 1'b1;
                        end
                    end
                    2'd1: begin
                        n_err = 1'b1;
                    end
                    2'd2: begin
                        if (n_pad == 2'd0 || n_pad == 2'd2) begin
                            push.count   = 2'd1;
                            push.item[0] = '{out_byte: n_acc[11:4], out_last: 1'b1,
                                             out_error: 1'b0};
                        end else begin
                            n_err = 1'b1;
                        end
                    end
                    default: begin
                        if (n_pad <= 2'd1) begin
                            push.count   = 2'd2;
                            push.item[0] = '{out_byte: n_acc[17:10], out_last: 1'b0,
                                             out_error: 1'b0};
                            push.item[1] = '{out_byte: n_acc[9:2], out_last: 1'b1,
                                             out_error: 1'b0};
                        end else begin
                            n_err = 1'b1;
                        end
                    end
                endcase
            end
            if (n_err) begin
                push         = '0;
                push.count   = 2'd1;
                push.item[0] = '{out_byte: 8'd0, out_last: 1'b1, out_error: 1'b1};
            end
            // Every message end starts the next message clean.
            n_acc   = '0;
            n_phase = 2'd0;
            n_pad   = 2'd0;
            n_err   = 1'b0;
        end

        if (!i_accept) begin
            push.count = 2'd0;
        end
    end

    assign o_push = push;

    // Message state, updated only on an accepted word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_phase <= 2'd0;
            r_pad   <= 2'd0;
            r_err   <= 1'b0;
        end else if (i_accept) begin
            r_acc   <= n_acc;
            r_phase <= n_phase;
            r_pad   <= n_pad;
            r_err   <= n_err;
        end
    end

    // Alphabet select register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_url <= 1'b0;
        end else if (i_cfg_we) begin
            r_url <= i_cfg_url;
        end
    end

endmodule

/* src/b64ld_outq.sv */
// ----------------------------------------------------------------------------
// Base64 lenient decoder output queue
// Small result queue that takes up to three words per cycle and drains one.
// ----------------------------------------------------------------------------
module b64ld_outq (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  b64ld_pkg::t_push       i_push,
    input  logic                   i_pop,
    output logic                   o_valid,
    output logic                   o_room,
    output b64ld_pkg::t_result     o_head,
    output b64ld_pkg::t_q_status   o_status
);

    b64ld_pkg::t_result             r_mem [b64ld_pkg::Q_DEPTH];
    logic [b64ld_pkg::Q_AW-1:0]     r_wr_ptr;
    logic [b64ld_pkg::Q_AW-1:0]     r_rd_ptr;
    logic [b64ld_pkg::Q_CW-1:0]     r_level;
    logic                           pop;

    assign pop     = i_pop && (r_level != '0);
    assign o_valid = (r_level != '0);
    assign o_head  = r_mem[r_rd_ptr];
    // Room for a full group of three results.
    assign o_room  = (r_level <= b64ld_pkg::Q_CW'(b64ld_pkg::Q_DEPTH - b64ld_pkg::MAX_PUSH));
    assign o_status.level = r_level;

    // Each entry takes the group word that lands on it.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < b64ld_pkg::Q_DEPTH; i++) begin
            logic [b64ld_pkg::Q_AW-1:0] offset;
            offset = b64ld_pkg::Q_AW'(i) - r_wr_ptr;
            if ({{(b64ld_pkg::Q_CW-b64ld_pkg::Q_AW){1'b0}}, offset}
                    < b64ld_pkg::Q_CW'(i_push.count)) begin
                r_mem[i] <= i_push.item[offset[1:0]];
            end
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + b64ld_pkg::Q_AW'(i_push.count);
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + b64ld_pkg::Q_AW'(1);
            end
            r_level <= r_level + b64ld_pkg::Q_CW'(i_push.count)
                       - b64ld_pkg::Q_CW'(pop);
        end
    end

endmodule

/* src/base64_lenient_decoder_top.sv */
// Results of an accepted word are registered in the result queue before output.
// Throughput: one encoded character per cycle while ready is high; a full group
// yields three bytes, drained one per ready cycle from an eight-entry result
// queue. Input ready is low while the queue has fewer than three free entries.
// Reset (synchronous, active low) clears the message state, the queue and
// selects the standard alphabet.
// ----------------------------------------------------------------------------
// Base64 lenient decoder top level
// Streaming base64 decoder with lenient padding and alphabet select.
// ----------------------------------------------------------------------------
module base64_lenient_decoder_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    b64ld_in_if.sink      i_in,
    b64ld_cfg_if.sink     i_cfg,
    b64ld_out_if.source   o_out
);

    b64ld_pkg::t_push      push;
    b64ld_pkg::t_result    head;
    b64ld_pkg::t_q_status  q_status;
    logic                  room;
    logic                  accept;

    assign i_in.ready  = room;
    assign accept      = i_in.valid && room;
    assign i_cfg.ready = 1'b1;

    // Decode state and result grouping.
    b64ld_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_byte    (i_in.in_byte),
        .i_last    (i_in.in_last),
        .i_cfg_we  (i_cfg.valid),
        .i_cfg_url (i_cfg.url_alphabet),
        .o_push    (push)
    );

    // Result queue toward the consumer.
    b64ld_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_pop    (o_out.ready),
        .o_valid  (o_out.valid),
        .o_room   (room),
        .o_head   (head),
        .o_status (q_status)
    );

    assign o_out.out_byte  = head.out_byte;
    assign o_out.out_last  = head.out_last;
    assign o_out.out_error = head.out_error;

`ifndef NO_ASSERTIONS
    // The queue never holds more words than it has entries.
    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_status.level <= b64ld_pkg::Q_CW'(b64ld_pkg::Q_DEPTH))
        else $error("output queue overflow");

    // An accepted word always finds room for a full group.
    a_room_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> q_status.level <= b64ld_pkg::Q_CW'(b64ld_pkg::Q_DEPTH
                                                       - b64ld_pkg::MAX_PUSH))
        else $error("word accepted without queue room");

    // An error result closes its message and carries a zero byte.
    a_error_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.out_error) |-> (o_out.out_last && o_out.out_byte == 8'd0))
        else $error("malformed error result");

    // A word pushed into an empty queue shows up on the output next cycle.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_status.level == '0 && push.count != 2'd0) |=> o_out.valid)
        else $error("pushed result not presented");
`endif

endmodule
